[rtl/bssd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bssd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CntW  = 3;
	localparam int unsigned IdxW  = 2;

	typedef logic [ByteW-1:0] byte_t;

	// configuration register indexes
	typedef enum logic [IdxW-1:0] {
		REG_FLAG     = 2'd0,
		REG_ESCAPE   = 2'd1,
		REG_ESC_FLAG = 2'd2,
		REG_ESC_ESC  = 2'd3
	} reg_idx_t;

	localparam byte_t FLAG_RST     = 8'd192;
	localparam byte_t ESCAPE_RST   = 8'd219;
	localparam byte_t ESC_FLAG_RST = 8'd220;
	localparam byte_t ESC_ESC_RST  = 8'd221;

endpackage

`default_nettype wire

[rtl/bit_serial_slip_deframer_core.sv]
// A line bit accepted into the input stage register is decoded when that stage fires
// (output free or unstalled); any word it completes is registered at that firing edge.
// Throughput: one bit per cycle unless the output stalls, set by the combinational
// compare and shift logic between the input stage register and the output register.
// Reset (arst_n low): hunting, nothing pending, both stages empty, codes at defaults.
`timescale 1ns / 1ps
`default_nettype none

module bit_serial_slip_deframer_core
	import bssd_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [IdxW-1:0] cfg_index,
	input  wire logic [ByteW-1:0] cfg_data,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic            rx_bit,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [ByteW-1:0]     data_byte,
	output logic                 last_byte,
	output logic                 empty_frame
);

	byte_t flag_q, escape_q, esc_flag_q, esc_esc_q;

	byte_t           shift_q, pend_q, prev_q;
	logic [CntW-1:0] cnt_q;
	logic            in_frame_q, pend_valid_q;

	logic rx_bit_s1, valid_s1;

	logic            adv, fire, accept;
	byte_t           sh, shift_n, pend_n, prev_n;
	logic [CntW-1:0] cnt_n;
	logic            in_frame_n, pend_valid_n;
	logic            res_valid, res_last, res_empty;
	byte_t           res_data;

	logic [ByteW-1:0] data_q;
	logic             last_q, empty_q, out_valid_q;

	assign adv      = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q     <= FLAG_RST;
			escape_q   <= ESCAPE_RST;
			esc_flag_q <= ESC_FLAG_RST;
			esc_esc_q  <= ESC_ESC_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FLAG:     flag_q     <= cfg_data;
				REG_ESCAPE:   escape_q   <= cfg_data;
				REG_ESC_FLAG: esc_flag_q <= cfg_data;
				REG_ESC_ESC:  esc_esc_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage: hold the bit while the output side is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_bit_s1 <= rx_bit;
		end
	end

	always_comb begin
		sh           = {shift_q[ByteW-2:0], rx_bit_s1};
		shift_n      = sh;
		cnt_n        = cnt_q;
		in_frame_n   = in_frame_q;
		pend_n       = pend_q;
		pend_valid_n = pend_valid_q;
		prev_n       = prev_q;
		res_valid    = 1'b0;
		res_data     = pend_q;
		res_last     = 1'b0;
		res_empty    = 1'b0;
		if (!in_frame_q) begin
			if (sh == flag_q) begin
				in_frame_n   = 1'b1;
				cnt_n        = '0;
				shift_n      = '0;
				prev_n       = '0;
				pend_valid_n = 1'b0;
			end
		end else begin
			cnt_n = cnt_q + 1'b1;
			if (cnt_n == '0) begin
				if (sh == flag_q) begin
					// close the frame, return to hunting
					res_valid    = 1'b1;
					res_last     = 1'b1;
					res_empty    = !pend_valid_q;
					res_data     = pend_valid_q ? pend_q : '0;
					in_frame_n   = 1'b0;
					pend_valid_n = 1'b0;
				end else if (pend_valid_q && prev_q == escape_q &&
						(sh == esc_flag_q || sh == esc_esc_q)) begin
					pend_n = (sh == esc_flag_q) ? flag_q : escape_q;
					prev_n = sh;
				end else begin
					res_valid    = pend_valid_q;
					pend_n       = sh;
					pend_valid_n = 1'b1;
					prev_n       = sh;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q      <= '0;
			cnt_q        <= '0;
			in_frame_q   <= 1'b0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			prev_q       <= '0;
		end else if (fire) begin
			shift_q      <= shift_n;
			cnt_q        <= cnt_n;
			in_frame_q   <= in_frame_n;
			pend_q       <= pend_n;
			pend_valid_q <= pend_valid_n;
			prev_q       <= prev_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (fire && res_valid) || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			data_q  <= res_data;
			last_q  <= res_last;
			empty_q <= res_empty;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_byte   = data_q;
	assign last_byte   = last_q;
	assign empty_frame = empty_q;

	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && empty_q |-> last_q && data_q == '0)
		else $error("empty frame word not closing or not zero");

	a_word_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid |-> in_frame_q && cnt_q == 3'd7)
		else $error("result outside a byte boundary");

	a_pend_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> in_frame_q)
		else $error("byte pending while hunting");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with no blocked output");

endmodule

`default_nettype wire
